// File: rtl/tbc_pkg.sv
package tbc_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 24;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
        logic signed [15:0] vert_a_x;
        logic signed [15:0] vert_a_y;
        logic signed [15:0] vert_a_z;
        logic signed [15:0] vert_b_x;
        logic signed [15:0] vert_b_y;
        logic signed [15:0] vert_b_z;
        logic signed [15:0] vert_c_x;
        logic signed [15:0] vert_c_y;
        logic signed [15:0] vert_c_z;
    } t_bary_in;

    typedef struct packed {
        logic signed [31:0] coord_s;
        logic signed [31:0] coord_t;
        logic               valid_res;
        logic               saturated;
    } t_bary_out;

endpackage

// File: rtl/tbc_if.sv
interface tbc_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/triangle_barycentric_coords_unit.sv
// Throughput: one beat per cycle while o_res is ready; 9 arithmetic stages,
// 33 restoring-divider stages (one quotient bit each, overflow test first)
// and the output register.
// Every stage stalls only when it is full and the stage after it is stalled.
// Reset (i_rst_n low at a clock edge, synchronous) empties all stages.
module triangle_barycentric_coords_unit
    import tbc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tbc_if.sink    i_item,
    tbc_if.source  o_res
);

    // Widths of the exact integer datapath.
    localparam int DW    = COORD_WIDTH + 1;     // coordinate difference
    localparam int PW    = 2 * DW;              // product of two differences
    localparam int XW    = PW + 1;              // cross-product component
    localparam int HL    = (XW + 1) / 2;        // low split of a component
    localparam int HH    = XW - HL;             // high split of a component
    localparam int PPW   = 2 * HL + 2;          // partial product
    localparam int QW    = 2 * XW;              // full dot-product term
    localparam int WW    = QW + 2;              // weight
    localparam int SW    = WW + 2;              // weight sum
    localparam int CMPW  = SW + 34;             // divider remainder
    localparam int EXW   = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;
    localparam int NFRONT = 9;
    localparam int NDIV   = 33;
    localparam int NST    = NFRONT + NDIV + 1;
    localparam int LAST   = NST - 1;

    // Difference vectors: u=B-A, v=C-A, p=A-T, q=B-T, r=C-T.
    localparam int D_U = 0;
    localparam int D_V = 1;
    localparam int D_P = 2;
    localparam int D_Q = 3;
    localparam int D_R = 4;
    // Cross products: N=u x v, then (q x r), (r x p), (p x q) for w0, w1, w2.
    localparam int XA[4] = '{D_U, D_Q, D_R, D_P};
    localparam int XB[4] = '{D_V, D_R, D_P, D_Q};

    function automatic logic signed [DW-1:0] f_coord(input logic [15:0] x);
        logic [EXW-1:0] xe;
        xe = EXW'(x);
        return DW'($signed(xe[COORD_WIDTH-1:0]));
    endfunction

    // ---------------------------------------------------------------
    // Stage valid bits and the ready chain: a stage loads when it is
    // empty or its content moves on.
    // ---------------------------------------------------------------
    logic [NST-1:0] r_v;
    logic [NST-1:0] stg_en;

    always_comb begin
        stg_en[LAST] = !r_v[LAST] || o_res.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            stg_en[k] = !r_v[k] || stg_en[k+1];
        end
    end

    assign i_item.ready = stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stg_en[0]) begin
                r_v[0] <= i_item.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (stg_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: coordinate differences.
    // ---------------------------------------------------------------
    logic signed [DW-1:0] n_dif [5][3];
    logic signed [DW-1:0] r_dif [5][3];

    always_comb begin
        logic signed [DW-1:0] ct [3];
        logic signed [DW-1:0] ca [3];
        logic signed [DW-1:0] cb [3];
        logic signed [DW-1:0] cc [3];
        ct[0] = f_coord(i_item.data.target_x);
        ct[1] = f_coord(i_item.data.target_y);
        ct[2] = f_coord(i_item.data.target_z);
        ca[0] = f_coord(i_item.data.vert_a_x);
        ca[1] = f_coord(i_item.data.vert_a_y);
        ca[2] = f_coord(i_item.data.vert_a_z);
        cb[0] = f_coord(i_item.data.vert_b_x);
        cb[1] = f_coord(i_item.data.vert_b_y);
        cb[2] = f_coord(i_item.data.vert_b_z);
        cc[0] = f_coord(i_item.data.vert_c_x);
        cc[1] = f_coord(i_item.data.vert_c_y);
        cc[2] = f_coord(i_item.data.vert_c_z);
        for (int c = 0; c < 3; c++) begin
            n_dif[D_U][c] = cb[c] - ca[c];
            n_dif[D_V][c] = cc[c] - ca[c];
            n_dif[D_P][c] = ca[c] - ct[c];
            n_dif[D_Q][c] = cb[c] - ct[c];
            n_dif[D_R][c] = cc[c] - ct[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_dif <= n_dif;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: the two products of every cross-product component.
    // ---------------------------------------------------------------
    logic signed [PW-1:0] n_pr [4][3][2];
    logic signed [PW-1:0] r_pr [4][3][2];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 3; c++) begin
                n_pr[k][c][0] = r_dif[XA[k]][(c+1)%3] * r_dif[XB[k]][(c+2)%3];
                n_pr[k][c][1] = r_dif[XA[k]][(c+2)%3] * r_dif[XB[k]][(c+1)%3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_pr <= n_pr;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: cross-product components.
    // ---------------------------------------------------------------
    logic signed [XW-1:0] n_x [4][3];
    logic signed [XW-1:0] r_x [4][3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 3; c++) begin
                n_x[k][c] = XW'(r_pr[k][c][0]) - XW'(r_pr[k][c][1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_x <= n_x;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: split each dot-product term into four partial products
    // (signed high half, unsigned low half) to keep multipliers narrow.
    // ---------------------------------------------------------------
    logic signed [PPW-1:0] n_pp [3][3][4];
    logic signed [PPW-1:0] r_pp [3][3][4];

    always_comb begin
        logic signed [HH-1:0] ah;
        logic signed [HH-1:0] bh;
        logic signed [HL:0]   al;
        logic signed [HL:0]   bl;
        for (int m = 0; m < 3; m++) begin
            for (int c = 0; c < 3; c++) begin
                ah = r_x[0][c][XW-1:HL];
                al = $signed({1'b0, r_x[0][c][HL-1:0]});
                bh = r_x[m+1][c][XW-1:HL];
                bl = $signed({1'b0, r_x[m+1][c][HL-1:0]});
                n_pp[m][c][0] = ah * bh;
                n_pp[m][c][1] = ah * bl;
                n_pp[m][c][2] = al * bh;
                n_pp[m][c][3] = al * bl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_pp <= n_pp;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: recombine partial products into full terms.
    // ---------------------------------------------------------------
    logic signed [QW-1:0] n_prod [3][3];
    logic signed [QW-1:0] r_prod [3][3];

    always_comb begin
        for (int m = 0; m < 3; m++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[m][c] = (QW'(r_pp[m][c][0]) <<< (2 * HL))
                             + (QW'(r_pp[m][c][1]) <<< HL)
                             + (QW'(r_pp[m][c][2]) <<< HL)
                             + QW'(r_pp[m][c][3]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_prod <= n_prod;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: weights w0, w1, w2.
    // ---------------------------------------------------------------
    logic signed [WW-1:0] n_w [3];
    logic signed [WW-1:0] r_w [3];

    always_comb begin
        for (int m = 0; m < 3; m++) begin
            n_w[m] = WW'(r_prod[m][0]) + WW'(r_prod[m][1]) + WW'(r_prod[m][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r_w <= n_w;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: weight sum; carry w1 and w2.
    // ---------------------------------------------------------------
    logic signed [SW-1:0] r_sum;
    logic signed [WW-1:0] r_w6 [2];

    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            r_sum   <= SW'(r_w[0]) + SW'(r_w[1]) + SW'(r_w[2]);
            r_w6[0] <= r_w[1];
            r_w6[1] <= r_w[2];
        end
    end

    // ---------------------------------------------------------------
    // Stage 7: magnitudes and quotient signs; a negative sum flips both.
    // ---------------------------------------------------------------
    logic [SW-1:0] r_den;
    logic [WW-1:0] r_mag [2];
    logic          r_neg7 [2];
    logic          r_zero7;

    always_ff @(posedge i_clk) begin
        if (stg_en[7]) begin
            r_den   <= r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
            r_zero7 <= (r_sum == '0);
            for (int i = 0; i < 2; i++) begin
                r_mag[i]  <= r_w6[i][WW-1] ? WW'(-r_w6[i]) : WW'(r_w6[i]);
                r_neg7[i] <= r_w6[i][WW-1] ^ r_sum[SW-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 8: rounded dividend (mag * 2^(F+1) + den) and divisor 2*den.
    // ---------------------------------------------------------------
    logic [CMPW-1:0] r_rem8 [2];
    logic [SW:0]     r_d2_8;
    logic            r_neg8 [2];
    logic            r_zero8;

    always_ff @(posedge i_clk) begin
        if (stg_en[8]) begin
            for (int i = 0; i < 2; i++) begin
                r_rem8[i] <= (CMPW'(r_mag[i]) << (FRAC_BITS + 1)) + CMPW'(r_den);
                r_neg8[i] <= r_neg7[i];
            end
            r_d2_8  <= {r_den, 1'b0};
            r_zero8 <= r_zero7;
        end
    end

    // ---------------------------------------------------------------
    // Divider: stage j tests 2*den << (32-j). Stage 0 is the overflow
    // test (quotient 2^32, no subtract); once it fires, hold the rest.
    // ---------------------------------------------------------------
    logic [CMPW-1:0] r_drem  [NDIV][2];
    logic [32:0]     r_dq    [NDIV][2];
    logic [SW:0]     r_dd2   [NDIV];
    logic            r_dneg  [NDIV][2];
    logic            r_dzero [NDIV];

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        localparam int SH = 32 - j;
        logic [CMPW-1:0] n_rem [2];
        logic [32:0]     n_q   [2];

        always_comb begin
            logic [CMPW-1:0] rem_in;
            logic [32:0]     q_in;
            logic [CMPW-1:0] thr;
            logic            take;
            for (int i = 0; i < 2; i++) begin
                if (j == 0) begin
                    rem_in = r_rem8[i];
                    q_in   = '0;
                    thr    = CMPW'(r_d2_8) << SH;
                end else begin
                    rem_in = r_drem[(j > 0) ? j - 1 : 0][i];
                    q_in   = r_dq[(j > 0) ? j - 1 : 0][i];
                    thr    = CMPW'(r_dd2[(j > 0) ? j - 1 : 0]) << SH;
                end
                take     = (rem_in >= thr) && !q_in[32];
                n_rem[i] = (take && j != 0) ? rem_in - thr : rem_in;
                n_q[i]   = take ? (q_in | (33'd1 << SH)) : q_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (stg_en[NFRONT+j]) begin
                r_drem[j] <= n_rem;
                r_dq[j]   <= n_q;
                if (j == 0) begin
                    r_dd2[j]   <= r_d2_8;
                    r_dneg[j]  <= r_neg8;
                    r_dzero[j] <= r_zero8;
                end else begin
                    r_dd2[j]   <= r_dd2[(j > 0) ? j - 1 : 0];
                    r_dneg[j]  <= r_dneg[(j > 0) ? j - 1 : 0];
                    r_dzero[j] <= r_dzero[(j > 0) ? j - 1 : 0];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output stage: apply sign, clamp to 32 bits, zero the result of degenerate input.
    // ---------------------------------------------------------------
    t_bary_out n_out;
    t_bary_out r_out;

    always_comb begin
        logic [31:0] val [2];
        logic        sat;
        sat = 1'b0;
        for (int i = 0; i < 2; i++) begin
            if (!r_dneg[NDIV-1][i]) begin
                if (r_dq[NDIV-1][i] > 33'h07FFFFFFF) begin
                    sat    = 1'b1;
                    val[i] = 32'h7FFFFFFF;
                end else begin
                    val[i] = r_dq[NDIV-1][i][31:0];
                end
            end else begin
                if (r_dq[NDIV-1][i] > 33'h080000000) begin
                    sat    = 1'b1;
                    val[i] = 32'h80000000;
                end else begin
                    val[i] = 32'd0 - r_dq[NDIV-1][i][31:0];
                end
            end
        end
        if (r_dzero[NDIV-1]) begin
            n_out = '0;
        end else begin
            n_out.coord_s   = $signed(val[0]);
            n_out.coord_t   = $signed(val[1]);
            n_out.valid_res = 1'b1;
            n_out.saturated = sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[LAST]) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_v[LAST];
    assign o_res.data  = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.data.valid_res |->
            o_res.data.coord_s == 32'sd0 && o_res.data.coord_t == 32'sd0
            && !o_res.data.saturated)
        else $error("degenerate result not cleared");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.saturated |->
            o_res.data.valid_res
            && (o_res.data.coord_s == 32'sh7FFFFFFF || o_res.data.coord_s == 32'sh80000000
             || o_res.data.coord_t == 32'sh7FFFFFFF || o_res.data.coord_t == 32'sh80000000))
        else $error("saturated flag without clamped coordinate");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> r_v[0])
        else $error("accepted beat not captured");

    a_degen_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NFRONT] && r_dzero[0] |-> r_dd2[0] == '0)
        else $error("zero sum with nonzero divisor");

endmodule
